FILE: hdl/cgrd_pkg.sv
package cgrd_pkg;

    // field widths
    localparam int unsigned GAP_W  = 32;
    localparam int unsigned THR_W  = 14;
    localparam int unsigned TEMP_W = 15;
    localparam int unsigned HUM_W  = 14;
    localparam int unsigned FUNC_W = 2;
    localparam int unsigned RSN_W  = 3;
    localparam int unsigned CIDX_W = 2;

    localparam int unsigned TIME_BITS_DEF = 32;

    // item codes
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EVAL  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FORCE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

    // reason codes
    localparam logic [RSN_W-1:0] RSN_THROTTLED = 3'd0;
    localparam logic [RSN_W-1:0] RSN_UNCHANGED = 3'd1;
    localparam logic [RSN_W-1:0] RSN_FIRST     = 3'd2;
    localparam logic [RSN_W-1:0] RSN_PERIODIC  = 3'd3;
    localparam logic [RSN_W-1:0] RSN_STATUS    = 3'd4;
    localparam logic [RSN_W-1:0] RSN_TEMP      = 3'd5;
    localparam logic [RSN_W-1:0] RSN_HUMID     = 3'd6;
    localparam logic [RSN_W-1:0] RSN_FORCED    = 3'd7;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_MIN_GAP  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_GAP  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_TEMP_THR = 2'd2;
    localparam logic [CIDX_W-1:0] REG_HUM_THR  = 2'd3;

    // register reset values
    localparam logic [GAP_W-1:0] MIN_GAP_RST  = 32'd60000;
    localparam logic [GAP_W-1:0] MAX_GAP_RST  = 32'd300000;
    localparam logic [THR_W-1:0] TEMP_THR_RST = 14'd50;
    localparam logic [THR_W-1:0] HUM_THR_RST  = 14'd200;

    typedef struct packed {
        logic [GAP_W-1:0] min_gap_ms;
        logic [GAP_W-1:0] max_gap_ms;
        logic [THR_W-1:0] temp_threshold;
        logic [THR_W-1:0] humidity_threshold;
    } t_cfg;

    // what the display currently shows
    typedef struct packed {
        logic                     valid;
        logic                     sensor_ok;
        logic                     clock_ok;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
    } t_shown;

endpackage

FILE: hdl/cgrd_rule.sv
module cgrd_rule #(
    parameter int unsigned TIME_BITS = cgrd_pkg::TIME_BITS_DEF
) (
    input  logic [cgrd_pkg::FUNC_W-1:0]        i_func,
    input  logic                               i_sensor_ok,
    input  logic                               i_clock_ok,
    input  logic signed [cgrd_pkg::TEMP_W-1:0] i_temperature,
    input  logic [cgrd_pkg::HUM_W-1:0]         i_humidity,
    input  cgrd_pkg::t_shown                   i_shown,
    input  cgrd_pkg::t_cfg                     i_cfg,
    input  logic [TIME_BITS-1:0]               i_since_ms,
    output logic [cgrd_pkg::RSN_W-1:0]         o_reason
);

    localparam int unsigned CMP_W =
        (TIME_BITS > cgrd_pkg::GAP_W) ? TIME_BITS : cgrd_pkg::GAP_W;
    localparam int unsigned TD_W  = cgrd_pkg::TEMP_W + 1;

    logic [CMP_W-1:0]        since_x;
    logic [CMP_W-1:0]        min_x;
    logic [CMP_W-1:0]        max_x;
    logic signed [TD_W-1:0]  t_diff;
    logic [TD_W-1:0]         t_abs;
    logic [cgrd_pkg::HUM_W-1:0] h_abs;
    logic                    t_over;
    logic                    h_over;

    assign since_x = CMP_W'(i_since_ms);
    assign min_x   = CMP_W'(i_cfg.min_gap_ms);
    assign max_x   = CMP_W'(i_cfg.max_gap_ms);

    // exact differences, one extra bit for the signed temperature
    assign t_diff = TD_W'(i_temperature) - TD_W'(i_shown.temperature);
    assign t_abs  = t_diff[TD_W-1] ? TD_W'(-t_diff) : TD_W'(t_diff);
    assign h_abs  = (i_humidity >= i_shown.humidity) ? (i_humidity - i_shown.humidity)
                                                     : (i_shown.humidity - i_humidity);

    assign t_over = t_abs > TD_W'(i_cfg.temp_threshold);
    assign h_over = h_abs > i_cfg.humidity_threshold;

    always_comb begin
        priority if (i_func == cgrd_pkg::FUNC_FORCE) begin
            o_reason = cgrd_pkg::RSN_FORCED;
        end else if (!i_shown.valid) begin
            o_reason = cgrd_pkg::RSN_FIRST;
        end else if (since_x >= max_x) begin
            o_reason = cgrd_pkg::RSN_PERIODIC;
        end else if (since_x < min_x) begin
            o_reason = cgrd_pkg::RSN_THROTTLED;
        end else if (i_sensor_ok != i_shown.sensor_ok || i_clock_ok != i_shown.clock_ok) begin
            o_reason = cgrd_pkg::RSN_STATUS;
        end else if (i_sensor_ok && t_over) begin
            o_reason = cgrd_pkg::RSN_TEMP;
        end else if (i_sensor_ok && h_over) begin
            o_reason = cgrd_pkg::RSN_HUMID;
        end else begin
            o_reason = cgrd_pkg::RSN_UNCHANGED;
        end
    end

endmodule

FILE: hdl/change_gated_refresh_decider.sv
// change_gated_refresh_decider
// decides whether a new temperature/humidity reading is worth a display repaint
// input channel: i_in_valid / o_in_stall, a transaction is taken at a rising edge
//   with valid high and stall low; i_func selects tick (1 ms), evaluate or force
// output channel: o_out_valid / i_out_stall carrying o_repaint and o_reason;
//   evaluate and force transactions give one result, ticks and code 3 give none
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
//   ready is always high, write only while the block is idle
// flow: a transaction taken lands in the input register, the rule logic works on
//   that register, and its result is captured in the result register and offered there
// throughput: one transaction per cycle while o_in_stall is low, set by the single input
//   register feeding the rule logic and the result register
// stall: while the result register is held, a tick still passes through; an item
//   that needs a result waits in the input register and o_in_stall rises
// reset (synchronous, active low): both registers empty, counter zero, nothing
//   shown, config registers back to their default values
module change_gated_refresh_decider #(
    parameter int unsigned TIME_BITS = cgrd_pkg::TIME_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [cgrd_pkg::FUNC_W-1:0]        i_func,
    input  logic                               i_sensor_ok,
    input  logic                               i_clock_ok,
    input  logic signed [cgrd_pkg::TEMP_W-1:0] i_temperature,
    input  logic [cgrd_pkg::HUM_W-1:0]         i_humidity,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_repaint,
    output logic [cgrd_pkg::RSN_W-1:0]         o_reason,
    // config channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cgrd_pkg::CIDX_W-1:0]        i_cfg_index,
    input  logic [cgrd_pkg::GAP_W-1:0]         i_cfg_data
);

    // config registers
    cgrd_pkg::t_cfg r_cfg;

    // input register
    logic                               r_in_valid;
    logic [cgrd_pkg::FUNC_W-1:0]        r_func;
    logic                               r_sensor_ok;
    logic                               r_clock_ok;
    logic signed [cgrd_pkg::TEMP_W-1:0] r_temperature;
    logic [cgrd_pkg::HUM_W-1:0]         r_humidity;

    // decision state
    cgrd_pkg::t_shown     r_shown;
    cgrd_pkg::t_shown     n_shown;
    logic [TIME_BITS-1:0] r_since_ms;
    logic [TIME_BITS-1:0] n_since_ms;

    // result register
    logic                        r_out_valid;
    logic                        r_repaint;
    logic [cgrd_pkg::RSN_W-1:0]  r_reason;

    logic                        needs_out;
    logic                        advance;
    logic                        paint;
    logic [cgrd_pkg::RSN_W-1:0]  reason;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_gap_ms         <= cgrd_pkg::MIN_GAP_RST;
            r_cfg.max_gap_ms         <= cgrd_pkg::MAX_GAP_RST;
            r_cfg.temp_threshold     <= cgrd_pkg::TEMP_THR_RST;
            r_cfg.humidity_threshold <= cgrd_pkg::HUM_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cgrd_pkg::REG_MIN_GAP:  r_cfg.min_gap_ms <= i_cfg_data;
                cgrd_pkg::REG_MAX_GAP:  r_cfg.max_gap_ms <= i_cfg_data;
                cgrd_pkg::REG_TEMP_THR: begin
                    r_cfg.temp_threshold <= i_cfg_data[cgrd_pkg::THR_W-1:0];
                end
                cgrd_pkg::REG_HUM_THR: begin
                    r_cfg.humidity_threshold <= i_cfg_data[cgrd_pkg::THR_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // only evaluate and force produce a result
    assign needs_out = (r_func == cgrd_pkg::FUNC_EVAL) || (r_func == cgrd_pkg::FUNC_FORCE);

    // the held item moves on unless it needs the result register and that is blocked
    assign o_in_stall = r_in_valid && needs_out && r_out_valid && i_out_stall;
    assign advance    = r_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_func        <= i_func;
            r_sensor_ok   <= i_sensor_ok;
            r_clock_ok    <= i_clock_ok;
            r_temperature <= i_temperature;
            r_humidity    <= i_humidity;
        end
    end

    cgrd_rule #(
        .TIME_BITS (TIME_BITS)
    ) u_rule (
        .i_func        (r_func),
        .i_sensor_ok   (r_sensor_ok),
        .i_clock_ok    (r_clock_ok),
        .i_temperature (r_temperature),
        .i_humidity    (r_humidity),
        .i_shown       (r_shown),
        .i_cfg         (r_cfg),
        .i_since_ms    (r_since_ms),
        .o_reason      (reason)
    );

    assign paint = needs_out && (reason != cgrd_pkg::RSN_THROTTLED)
                             && (reason != cgrd_pkg::RSN_UNCHANGED);

    // state update: tick counts up with saturation, a paint stores the reading
    always_comb begin
        n_shown    = r_shown;
        n_since_ms = r_since_ms;
        if (advance) begin
            if (r_func == cgrd_pkg::FUNC_TICK) begin
                if (r_since_ms != {TIME_BITS{1'b1}}) begin
                    n_since_ms = r_since_ms + TIME_BITS'(1);
                end
            end else if (paint) begin
                n_shown.valid       = 1'b1;
                n_shown.sensor_ok   = r_sensor_ok;
                n_shown.clock_ok    = r_clock_ok;
                n_shown.temperature = r_sensor_ok ? r_temperature : '0;
                n_shown.humidity    = r_sensor_ok ? r_humidity : '0;
                n_since_ms          = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shown    <= '0;
            r_since_ms <= '0;
        end else begin
            r_shown    <= n_shown;
            r_since_ms <= n_since_ms;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && needs_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && needs_out) begin
            r_repaint <= paint;
            r_reason  <= reason;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_repaint   = r_repaint;
    assign o_reason    = r_reason;

endmodule

FILE: hdl/cgrd_checker.sv
module cgrd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_repaint,
    input logic [cgrd_pkg::RSN_W-1:0]  o_reason
);

    // repaint flag agrees with the reason code
    a_repaint_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_repaint == ((o_reason != cgrd_pkg::RSN_THROTTLED) &&
                                       (o_reason != cgrd_pkg::RSN_UNCHANGED))))
        else $error("repaint does not match reason");

    // input side only waits on a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while output free");

    // both sides come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("not empty after reset");

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_reason) && $stable(o_repaint)))
        else $error("stalled result changed");

endmodule

bind change_gated_refresh_decider cgrd_checker u_cgrd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_repaint   (o_repaint),
    .o_reason    (o_reason)
);
